>>> hw/rtl/kpc_pkg.sv
// ----------------------------------------------------------------------------
// kpc_pkg: shared types and constants of the key press classifier
// Field widths, event and register codes, and reset values of the settings.
// ----------------------------------------------------------------------------
package kpc_pkg;

  // Widths of the fields carried on the ports.
  localparam int unsigned LEVEL_W    = 4;
  localparam int unsigned KEY_W      = 2;
  localparam int unsigned KEY_CODE_W = 3;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned HOLD_W     = 6;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 8;

  // Key code meaning that no key is held.
  localparam logic [KEY_CODE_W-1:0] KEY_NONE = 3'd4;

  // Reset values of the settings registers.
  localparam logic [CNT_W-1:0]  SHORT_MIN_RST   = 8'd3;
  localparam logic [CNT_W-1:0]  LONG_COUNT_RST  = 8'd100;
  localparam logic [HOLD_W-1:0] HOLD_PERIOD_RST = 6'd20;

  // Event codes reported on the result channel.
  typedef enum logic [1:0] {
    EVT_SHORT     = 2'd0,
    EVT_LONG      = 2'd1,
    EVT_HOLD      = 2'd2,
    EVT_LONG_REL  = 2'd3
  } evt_t;

  // Settings register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SHORT_MIN   = 2'd0,
    CFG_LONG_COUNT  = 2'd1,
    CFG_HOLD_PERIOD = 2'd2
  } cfg_idx_t;

  // One result item.
  typedef struct packed {
    logic [KEY_W-1:0] key_index;
    evt_t             event_type;
  } result_t;

endpackage

>>> hw/rtl/kpc_out_skid.sv
// ----------------------------------------------------------------------------
// kpc_out_skid: result register with skid stage
// Holds up to two results so the classifier can keep taking items while the
// receiver stalls; the upstream stall comes straight from a register.
// ----------------------------------------------------------------------------
module kpc_out_skid
  import kpc_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    res_valid,
  input  result_t res_data,
  output logic    up_stall,
  output logic    out_valid,
  output result_t out_data,
  input  logic    out_stall
);

  logic    out_valid_r, out_valid_nxt;
  logic    skid_valid_r, skid_valid_nxt;
  result_t out_data_r, out_data_nxt;
  result_t skid_data_r, skid_data_nxt;
  logic    out_fire;

  assign out_fire = out_valid_r & ~out_stall;

  // Slot control: a new result goes to the output register when it frees up,
  // otherwise it waits in the skid stage.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_data_nxt   = out_data_r;
    skid_data_nxt  = skid_data_r;
    if (skid_valid_r) begin
      if (out_fire) begin
        out_data_nxt   = skid_data_r;
        skid_valid_nxt = 1'b0;
      end
    end else if (res_valid) begin
      if (!out_valid_r || out_fire) begin
        out_data_nxt  = res_data;
        out_valid_nxt = 1'b1;
      end else begin
        skid_data_nxt  = res_data;
        skid_valid_nxt = 1'b1;
      end
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    skid_data_r <= skid_data_nxt;
  end

  assign up_stall  = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hw/rtl/key_press_classifier.sv
// ----------------------------------------------------------------------------
// key_press_classifier: short, long, hold and long-release key detector
// Scans active-low key levels one key per tick and reports press events.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid, in_stall, in_key_levels): one transfer is one
//   scan tick carrying the raw levels of the keys, 0 meaning pressed.
//   Result channel (out_valid, out_stall, out_key_index, out_event_type):
//   zero or one event per tick, in tick order.
//   Settings port (cfg_valid, cfg_ready, cfg_index, cfg_data): writes
//   short_min, long_count and hold_period; cfg_ready is always high. Write
//   only while no tick is in flight.
//   Events are registered in the output register or the skid stage.
//   Throughput: one tick per cycle while in_stall is low; the state update
//   is a single pass of compare and increment logic between the state and
//   result registers. When the receiver stalls, results collect in the
//   output register and skid stage; in_stall rises only once both are full.
//   Reset clears the scan pointer, the counter and the held key, sets the
//   level image to all released and loads the default settings.
// ----------------------------------------------------------------------------
module key_press_classifier
  import kpc_pkg::*;
#(
  parameter int unsigned NUM_KEYS = 4
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [LEVEL_W-1:0]    in_key_levels,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [KEY_W-1:0]      out_key_index,
  output logic [1:0]            out_event_type,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Only as many keys as the level field has bits are scanned.
  localparam int unsigned KEYS  = (NUM_KEYS > LEVEL_W) ? LEVEL_W : NUM_KEYS;
  localparam int unsigned PTR_W = $clog2(KEYS);

  logic [CNT_W-1:0]      short_min_r;
  logic [CNT_W-1:0]      long_count_r;
  logic [HOLD_W-1:0]     hold_period_r;
  logic [PTR_W-1:0]      scan_ptr_r, scan_ptr_nxt;
  logic [KEYS-1:0]       image_r, image_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [KEY_CODE_W-1:0] prev_key_r, key_nxt;
  logic                  in_fire;
  logic [CNT_W-1:0]      count_inc;
  logic [CNT_W:0]        hold_limit;
  logic                  evt_valid;
  evt_t                  evt;
  logic                  res_valid;
  result_t               res_data;
  result_t               out_data;
  logic                  up_stall;

  assign in_fire   = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  // Settings registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_min_r   <= SHORT_MIN_RST;
      long_count_r  <= LONG_COUNT_RST;
      hold_period_r <= HOLD_PERIOD_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_SHORT_MIN:   short_min_r   <= cfg_data;
        CFG_LONG_COUNT:  long_count_r  <= cfg_data;
        CFG_HOLD_PERIOD: hold_period_r <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample the scanned key into the image and advance the pointer.
  always_comb begin
    image_nxt             = image_r;
    image_nxt[scan_ptr_r] = in_key_levels[scan_ptr_r];
    if (scan_ptr_r == PTR_W'(KEYS - 1)) begin
      scan_ptr_nxt = '0;
    end else begin
      scan_ptr_nxt = scan_ptr_r + 1'b1;
    end
  end

  // Lowest-index pressed key of the updated image.
  always_comb begin
    key_nxt = KEY_NONE;
    for (int k = KEYS - 1; k >= 0; k--) begin
      if (!image_nxt[k]) begin
        key_nxt = KEY_CODE_W'(k);
      end
    end
  end

  // Counter and event decision.
  assign count_inc  = count_r + 1'b1;
  assign hold_limit = {1'b0, long_count_r} + {3'b000, hold_period_r};

  always_comb begin
    evt_valid = 1'b0;
    evt       = EVT_SHORT;
    count_nxt = count_inc;
    if (key_nxt == KEY_NONE) begin
      count_nxt = '0;
      if (short_min_r < count_r && count_r < long_count_r) begin
        evt_valid = 1'b1;
        evt       = EVT_SHORT;
      end else if (long_count_r <= count_r) begin
        evt_valid = 1'b1;
        evt       = EVT_LONG_REL;
      end
    end else if (count_inc == short_min_r) begin
      evt_valid = 1'b0;
    end else if (count_inc == long_count_r) begin
      evt_valid = 1'b1;
      evt       = EVT_LONG;
    end else if ({1'b0, count_inc} == hold_limit) begin
      evt_valid = 1'b1;
      evt       = EVT_HOLD;
      count_nxt = long_count_r;
    end
    // A change of key restarts the count; the event above still stands.
    if (key_nxt != prev_key_r) begin
      count_nxt = '0;
    end
  end

  assign res_valid           = in_fire & evt_valid & (prev_key_r != KEY_NONE);
  assign res_data.key_index  = prev_key_r[KEY_W-1:0];
  assign res_data.event_type = evt;

  // Scan state, updated on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_ptr_r <= '0;
      image_r    <= '1;
      count_r    <= '0;
      prev_key_r <= KEY_NONE;
    end else if (in_fire) begin
      scan_ptr_r <= scan_ptr_nxt;
      image_r    <= image_nxt;
      count_r    <= count_nxt;
      prev_key_r <= key_nxt;
    end
  end

  // Result register and skid stage.
  kpc_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_data  (res_data),
    .up_stall  (up_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .out_stall (out_stall)
  );

  assign in_stall       = up_stall;
  assign out_key_index  = out_data.key_index;
  assign out_event_type = out_data.event_type;

endmodule

>>> test/key_press_classifier_test.sv
// ----------------------------------------------------------------------------
// key_press_classifier_test: self-checking bench for the key press classifier
// Drives scan ticks of four active-low keys through a randomly idling input
// channel, works out the expected short, long, hold and long-release events
// with a predictor of its own, and checks every event that leaves the block
// in order. The thresholds are changed between phases while nothing is in
// flight, covering low and high values.
// ----------------------------------------------------------------------------
module key_press_classifier_test;
  import kpc_pkg::*;

  localparam int unsigned NUM_KEYS    = 4;
  localparam int          KEYS        = (NUM_KEYS > LEVEL_W) ? LEVEL_W : NUM_KEYS;
  localparam int          IDLE_PCT    = 21;
  localparam int unsigned CYCLE_LIMIT = 200000;

  // Clock and the block's ports; the driven ones are known from time zero.
  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [LEVEL_W-1:0]    in_key_levels = '1;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [KEY_W-1:0]      out_key_index;
  logic [1:0]            out_event_type;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_SHORT_MIN;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Ticks waiting to be sent and events waiting to be seen.
  logic [LEVEL_W-1:0] level_q[$];
  result_t            pending_events[$];
  int                 queued_total = 0;
  int                 mismatches = 0;
  int unsigned        cycle_count = 0;
  bit                 steady_run = 1'b0;
  result_t            want;

  // Predictor copy of the thresholds.
  logic [CNT_W-1:0]  set_short_min   = SHORT_MIN_RST;
  logic [CNT_W-1:0]  set_long_count  = LONG_COUNT_RST;
  logic [HOLD_W-1:0] set_hold_period = HOLD_PERIOD_RST;

  // Predictor copy of the scan and press state.
  int                    scan_ptr    = 0;
  logic [LEVEL_W-1:0]    level_image = '1;
  logic [CNT_W-1:0]      press_count = '0;
  logic [KEY_CODE_W-1:0] held_key    = KEY_NONE;

  key_press_classifier #(
    .NUM_KEYS(NUM_KEYS)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_key_levels (in_key_levels),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_key_index (out_key_index),
    .out_event_type(out_event_type),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // Free-running clock, period 20.
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Works out the event, if any, caused by one accepted scan tick.
  task automatic classify_tick(input logic [LEVEL_W-1:0] levels);
    logic [KEY_CODE_W-1:0] found;
    logic [CNT_W:0]        hold_mark;
    evt_t                  ev;
    bit                    fired;
    result_t               ev_item;
    int                    k;
    found = KEY_NONE;
    fired = 1'b0;
    ev = EVT_SHORT;
    hold_mark = {1'b0, set_long_count} + set_hold_period;

    // Copy the level of the key under the scan pointer into the image.
    if (scan_ptr < KEYS) level_image[scan_ptr] = levels[scan_ptr];
    scan_ptr = (scan_ptr + 1 >= KEYS) ? 0 : scan_ptr + 1;

    // The lowest-index pressed key wins.
    for (k = KEYS - 1; k >= 0; k--) begin
      if (!level_image[k]) found = KEY_CODE_W'(k);
    end

    if (found == KEY_NONE) begin
      // Release: the length of the press picks short or long release.
      if (set_short_min < press_count && press_count < set_long_count) begin
        ev = EVT_SHORT;
        fired = 1'b1;
      end else if (set_long_count <= press_count) begin
        ev = EVT_LONG_REL;
        fired = 1'b1;
      end
      press_count = '0;
    end else begin
      // Still down: count, then the first matching threshold decides.
      press_count = press_count + 1'b1;
      if (press_count == set_short_min) begin
        fired = 1'b0;
      end else if (press_count == set_long_count) begin
        ev = EVT_LONG;
        fired = 1'b1;
      end else if ({1'b0, press_count} == hold_mark) begin
        ev = EVT_HOLD;
        fired = 1'b1;
        press_count = set_long_count;
      end
    end

    // A change of key restarts the count; the event keeps the old key.
    if (found != held_key) press_count = '0;
    if (held_key != KEY_NONE && fired) begin
      ev_item.key_index  = held_key[KEY_W-1:0];
      ev_item.event_type = ev;
      pending_events.push_back(ev_item);
    end
    held_key = found;
  endtask

  // Driver: feeds queued ticks, idling at random, holding while stalled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) classify_tick(in_key_levels);
      if (in_valid && in_stall) begin
        in_valid <= 1'b1;
      end else if (level_q.size() != 0 &&
                   (steady_run || $urandom_range(0, 99) >= IDLE_PCT)) begin
        in_valid      <= 1'b1;
        in_key_levels <= level_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: checks each event transfer against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_events.size() == 0) begin
          if (mismatches < 10)
            $display("Unexpected event: key %0d type %0d", out_key_index, out_event_type);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          if (out_key_index !== want.key_index || out_event_type !== want.event_type) begin
            if (mismatches < 10)
              $display("Event mismatch: expected key %0d type %0d, got key %0d type %0d",
                       want.key_index, want.event_type, out_key_index, out_event_type);
            mismatches++;
          end
        end
      end
      out_stall <= !steady_run && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  // Watchdog on the length of the run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Queues the same level pattern for a number of ticks.
  task automatic push_run(input logic [LEVEL_W-1:0] levels, input int ticks);
    repeat (ticks) begin
      level_q.push_back(levels);
      queued_total++;
    end
  endtask

  // Writes one threshold register and mirrors it in the predictor.
  task automatic write_setting(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_SHORT_MIN:   set_short_min   = value;
      CFG_LONG_COUNT:  set_long_count  = value;
      CFG_HOLD_PERIOD: set_hold_period = value[HOLD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input int short_min, input int long_count, input int hold);
    write_setting(CFG_SHORT_MIN, CFG_DATA_W'(short_min));
    write_setting(CFG_LONG_COUNT, CFG_DATA_W'(long_count));
    write_setting(CFG_HOLD_PERIOD, CFG_DATA_W'(hold));
  endtask

  // Waits until every tick is sent and every event seen, then lets the
  // block settle before anything is reconfigured.
  task automatic wait_for_quiet();
    while (level_q.size() != 0 || in_valid || pending_events.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Random presses sized to the current thresholds: mostly clean presses
  // and releases, some presses that switch key, and some raw noise.
  task automatic queue_presses(input int budget);
    int                 start;
    int                 kind;
    int                 k;
    int                 k2;
    int                 dur;
    logic [LEVEL_W-1:0] below;
    logic [LEVEL_W-1:0] pat;
    start = queued_total;
    while (queued_total - start < budget) begin
      kind  = $urandom_range(0, 99);
      k     = $urandom_range(0, KEYS - 1);
      below = (LEVEL_W'(1) << k) - LEVEL_W'(1);
      pat   = (LEVEL_W'($urandom) | below) & ~(LEVEL_W'(1) << k);
      case ($urandom_range(0, 2))
        0:       dur = $urandom_range(1, set_short_min + 4);
        1:       dur = $urandom_range(set_short_min, set_long_count + 4);
        default: dur = $urandom_range(set_long_count, set_long_count + 3 * set_hold_period + 6);
      endcase
      if (dur > 320) dur = 320;
      if (dur < 1) dur = 1;
      if (kind < 70) begin
        push_run(pat, dur);
        push_run('1, $urandom_range(4, 10));
      end else if (kind < 85) begin
        k2 = (k + $urandom_range(1, KEYS - 1)) % KEYS;
        push_run(pat, dur / 2 + 1);
        push_run(~(LEVEL_W'(1) << k2), $urandom_range(1, dur));
        if ($urandom_range(0, 1)) push_run('1, $urandom_range(1, 10));
      end else begin
        repeat ($urandom_range(1, 8)) push_run(LEVEL_W'($urandom), 1);
      end
    end
  endtask

  // Main sequence of phases.
  initial begin
    int s;
    int l;
    int h;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset thresholds: released, all pressed, keys 2 and 3 alone, changes of key.
    push_run(4'hF, 1);
    push_run(4'h0, 6);
    push_run(4'hF, 4);
    push_run(4'hB, 5);
    push_run(4'h7, 5);
    push_run(4'hF, 4);
    queue_presses(120);
    wait_for_quiet();

    // Low thresholds: long at once, then a hold every tick.
    set_thresholds(0, 1, 1);
    queue_presses(120);
    wait_for_quiet();

    // High thresholds; the last press stays down into the next phase.
    set_thresholds(254, 200, 55);
    push_run(4'hE, 270);
    push_run(4'hF, 6);
    push_run(4'hD, 12);
    push_run(4'hF, 6);
    push_run(4'hE, 220);
    wait_for_quiet();

    // Short threshold equal to long: no long event, and the held count
    // from before wraps round past its top.
    set_thresholds(5, 5, 3);
    push_run(4'hE, 60);
    push_run(4'hF, 6);
    queue_presses(100);
    wait_for_quiet();

    // A long stretch without any idling on either side.
    set_thresholds(2, 12, 4);
    steady_run = 1'b1;
    queue_presses(200);
    wait_for_quiet();
    steady_run = 1'b0;

    // Random thresholds, some with short_min forced to or above long_count.
    repeat (3) begin
      l = $urandom_range(1, 30);
      s = $urandom_range(0, 12);
      h = $urandom_range(1, 8);
      if ($urandom_range(0, 2) == 0) s = l + $urandom_range(0, 5);
      set_thresholds(s, l, h);
      queue_presses(80);
      wait_for_quiet();
    end

    if (mismatches == 0 && pending_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/kpc_pkg.sv
hw/rtl/kpc_out_skid.sv
hw/rtl/key_press_classifier.sv
test/key_press_classifier_test.sv
